>>> hdl/wlf_pkg.sv
// shared constants for the waveset length filter
// register indexes, filter mode codes, field widths and parameter defaults
// no dependencies
package wlf_pkg;

  // parameter defaults
  localparam int unsigned CycleStoreDef = 64;
  localparam int unsigned SampleBitsDef = 16;

  // configuration field widths
  localparam int unsigned ModeBits    = 2;
  localparam int unsigned LimitBits   = 7;
  localparam int unsigned CfgIdxBits  = 4;
  localparam int unsigned CfgDataBits = 7;

  // register indexes
  localparam logic [CfgIdxBits-1:0] RegFilterMode = 4'd0;
  localparam logic [CfgIdxBits-1:0] RegLongLimit  = 4'd1;
  localparam logic [CfgIdxBits-1:0] RegShortLimit = 4'd2;
  localparam logic [CfgIdxBits-1:0] RegStartPol   = 4'd3;

  // filter modes, the unused code behaves as band-pass
  localparam logic [ModeBits-1:0] ModeHighPass = 2'd0;
  localparam logic [ModeBits-1:0] ModeLowPass  = 2'd1;
  localparam logic [ModeBits-1:0] ModeBandPass = 2'd2;

  // reset values
  localparam logic [ModeBits-1:0]  ModeReset       = ModeHighPass;
  localparam logic [LimitBits-1:0] LongLimitReset  = 7'd64;
  localparam logic [LimitBits-1:0] ShortLimitReset = 7'd1;

endpackage

>>> hdl/wlf_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no reset on contents; used for the cycle store
// no dependencies
module wlf_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/waveset_length_filter_top.sv
// waveset length filter top level: splits samples into zero-crossing cycles,
// stores each cycle in a ram and replays the cycles whose length passes
// depends on wlf_pkg and wlf_ram
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------------
//  in      | in        | in_valid_i / in_stall_o   | sample_in_i
//  out     | out       | out_valid_o / out_stall_i | sample_out_o, cycle_last_o
//  cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// a sample that does not end a kept cycle is taken without stalling the input
// a sample that ends a kept cycle holds the input while that cycle is replayed:
// the single ram read port gives one sample per read-then-load pair
// output stalls stretch the replay; the input is stalled while it runs
// reset clears control state only; the cycle store needs no clearing pass
// configuration writes are always ready and take effect at once
module waveset_length_filter_top #(
  parameter int unsigned CycleStore = wlf_pkg::CycleStoreDef,
  parameter int unsigned SampleBits = wlf_pkg::SampleBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // sample input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SampleBits-1:0]   sample_in_i,
  // sample output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SampleBits-1:0]   sample_out_o,
  output logic                           cycle_last_o,
  // configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wlf_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [wlf_pkg::CfgDataBits-1:0] cfg_data_i
);

  localparam int unsigned AddrW = $clog2(CycleStore);
  localparam int unsigned CntW  = $clog2(CycleStore + 1);
  localparam int unsigned CmpW  = (CntW > wlf_pkg::LimitBits) ? CntW : wlf_pkg::LimitBits;

  localparam logic [CntW-1:0] StoreFull = CntW'(CycleStore);
  localparam logic [CntW-1:0] CntOne    = CntW'(1);

  // replay sequencer
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StLoad = 2'd2;

  logic [1:0] state_q, state_d;

  // configuration registers
  logic [wlf_pkg::ModeBits-1:0]  mode_q;
  logic [wlf_pkg::LimitBits-1:0] long_q;
  logic [wlf_pkg::LimitBits-1:0] short_q;
  logic                          pol_q;

  // cycle tracking
  logic [CntW-1:0]  fill_q, fill_d;
  logic             second_q, second_d;
  logic             ovf_q, ovf_d;
  logic [AddrW-1:0] rd_idx_q, rd_idx_d;
  logic [SampleBits-1:0] pend_q;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [SampleBits-1:0] out_data_q;
  logic                  out_last_q;

  // ram ports
  logic                  ram_we, ram_re;
  logic [AddrW-1:0]      ram_waddr;
  logic [SampleBits-1:0] ram_wdata, ram_rdata;

  logic in_xfer, out_xfer, cfg_xfer;
  logic is_zero, is_neg, is_pos, opp_sign, start_sign;
  logic [CmpW-1:0] len_ext, long_ext, short_ext;
  logic too_long, too_short, dropped, load_last;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = (state_q != StIdle);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_q && !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;
  assign cycle_last_o = out_last_q;

  // sign of the incoming sample against the starting polarity
  assign is_zero    = (sample_in_i == '0);
  assign is_neg     = sample_in_i[SampleBits-1];
  assign is_pos     = !is_zero && !is_neg;
  assign opp_sign   = pol_q ? is_pos : is_neg;
  assign start_sign = pol_q ? is_neg : is_pos;

  assign len_ext   = CmpW'(fill_q);
  assign long_ext  = CmpW'(long_q);
  assign short_ext = CmpW'(short_q);
  assign too_long  = len_ext > long_ext;
  assign too_short = len_ext < short_ext;

  always_comb begin
    case (mode_q)
      wlf_pkg::ModeHighPass: dropped = too_long;
      wlf_pkg::ModeLowPass:  dropped = too_short;
      default:               dropped = too_long || too_short;
    endcase
  end

  assign load_last = (CntW'(rd_idx_q) + CntOne == fill_q);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    second_d    = second_q;
    ovf_d       = ovf_q;
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q && !out_xfer;
    ram_we      = 1'b0;
    ram_waddr   = fill_q[AddrW-1:0];
    ram_wdata   = sample_in_i;
    ram_re      = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (second_q && start_sign) begin
            // cycle ends before this sample
            second_d = 1'b0;
            ovf_d    = 1'b0;
            if (!ovf_q && !dropped && fill_q != '0) begin
              rd_idx_d = '0;
              state_d  = StRead;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              fill_d    = CntOne;
            end
          end else begin
            if (!second_q && opp_sign) begin
              second_d = 1'b1;
            end
            if (fill_q < StoreFull) begin
              ram_we = 1'b1;
              fill_d = fill_q + CntOne;
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
      end
      StRead: begin
        // only read once the output register is sure to be free next cycle
        if (!out_valid_q || !out_stall_i) begin
          ram_re  = 1'b1;
          state_d = StLoad;
        end
      end
      StLoad: begin
        out_valid_d = 1'b1;
        if (load_last) begin
          // replay done, the held sample opens the next cycle
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = pend_q;
          fill_d    = CntOne;
          state_d   = StIdle;
        end else begin
          rd_idx_d = rd_idx_q + AddrW'(1);
          state_d  = StRead;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      second_q    <= 1'b0;
      ovf_q       <= 1'b0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
      mode_q      <= wlf_pkg::ModeReset;
      long_q      <= wlf_pkg::LongLimitReset;
      short_q     <= wlf_pkg::ShortLimitReset;
      pol_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      second_q    <= second_d;
      ovf_q       <= ovf_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_xfer) begin
        case (cfg_index_i)
          wlf_pkg::RegFilterMode: mode_q  <= cfg_data_i[wlf_pkg::ModeBits-1:0];
          wlf_pkg::RegLongLimit:  long_q  <= cfg_data_i[wlf_pkg::LimitBits-1:0];
          wlf_pkg::RegShortLimit: short_q <= cfg_data_i[wlf_pkg::LimitBits-1:0];
          wlf_pkg::RegStartPol:   pol_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pend_q <= sample_in_i;
    end
    if (state_q == StLoad) begin
      out_data_q <= ram_rdata;
      out_last_q <= load_last;
    end
  end

  wlf_ram #(
    .Width(SampleBits),
    .Depth(CycleStore)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(rd_idx_q),
    .rdata_o(ram_rdata)
  );

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= StoreFull)
    else $error("fill count beyond store depth");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLoad) |-> !out_valid_q)
    else $error("output register busy when ram data arrives");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLoad) |=> out_valid_q)
    else $error("replayed sample not presented");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead || state_q == StLoad) |-> (CntW'(rd_idx_q) < fill_q))
    else $error("replay index past cycle length");

  a_no_input_in_replay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLoad) |=> (fill_q == CntOne || state_q == StRead))
    else $error("replay step left store in wrong state");
`endif

endmodule

>>> tb/wlf_replay_checker.sv
// replay checker for the waveset length filter
// watches the sample, replay and register channels, predicts the replayed cycles
// and compares them in order; depends on wlf_pkg
module wlf_replay_checker #(
  parameter int unsigned CycleStore = wlf_pkg::CycleStoreDef,
  parameter int unsigned SampleBits = wlf_pkg::SampleBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic signed [SampleBits-1:0]    sample_in_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic signed [SampleBits-1:0]    sample_out_i,
  input  logic                            cycle_last_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [wlf_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [wlf_pkg::CfgDataBits-1:0] cfg_data_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);

  localparam int unsigned ModeBits  = wlf_pkg::ModeBits;
  localparam int unsigned LimitBits = wlf_pkg::LimitBits;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic                         last;
  } replay_t;

  // predicted register copies
  logic [ModeBits-1:0]  mode_r;
  logic [LimitBits-1:0] long_r;
  logic [LimitBits-1:0] short_r;
  logic                 lead_negative;

  // predicted cycle state
  logic signed [SampleBits-1:0] held [CycleStore];
  int unsigned                  held_count;
  logic                         in_second_half;
  logic                         lost_samples;

  replay_t     replay_q [$];
  int unsigned mismatches;
  int unsigned outstanding;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  task automatic report_mismatch(input string what);
    $display("%0t replay check: %s", $time, what);
    mismatches++;
  endtask

  function automatic int sign_of(input logic signed [SampleBits-1:0] v);
    if (v == 0) begin
      return 0;
    end
    return (v < 0) ? -1 : 1;
  endfunction

  function automatic logic length_rejected(input int unsigned len);
    logic too_long;
    logic too_short;
    too_long  = len > long_r;
    too_short = len < short_r;
    case (mode_r)
      wlf_pkg::ModeHighPass: return too_long;
      wlf_pkg::ModeLowPass:  return too_short;
      default:               return too_long || too_short;
    endcase
  endfunction

  task automatic hold_sample(input logic signed [SampleBits-1:0] v);
    if (held_count < CycleStore) begin
      held[held_count] = v;
      held_count++;
    end else begin
      lost_samples = 1'b1;
    end
  endtask

  task automatic track_sample(input logic signed [SampleBits-1:0] v);
    int      sg;
    int      lead;
    replay_t r;
    sg   = sign_of(v);
    lead = lead_negative ? -1 : 1;
    if (!in_second_half) begin
      if (sg == -lead) begin
        in_second_half = 1'b1;
      end
      hold_sample(v);
    end else if (sg != lead) begin
      hold_sample(v);
    end else begin
      // a sample of the leading sign closes the cycle and opens the next one
      if (!lost_samples && !length_rejected(held_count)) begin
        for (int unsigned k = 0; k < held_count; k++) begin
          r.sample = held[k];
          r.last   = (k + 1 == held_count);
          replay_q.push_back(r);
        end
      end
      held_count     = 0;
      lost_samples   = 1'b0;
      in_second_half = 1'b0;
      hold_sample(v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    replay_t got;
    replay_t want;
    if (!rst_ni) begin
      mode_r         = wlf_pkg::ModeReset;
      long_r         = wlf_pkg::LongLimitReset;
      short_r        = wlf_pkg::ShortLimitReset;
      lead_negative  = 1'b0;
      held_count     = 0;
      in_second_half = 1'b0;
      lost_samples   = 1'b0;
      mismatches     = 0;
      replay_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          wlf_pkg::RegFilterMode: mode_r        = cfg_data_i[ModeBits-1:0];
          wlf_pkg::RegLongLimit:  long_r        = cfg_data_i[LimitBits-1:0];
          wlf_pkg::RegShortLimit: short_r       = cfg_data_i[LimitBits-1:0];
          wlf_pkg::RegStartPol:   lead_negative = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        track_sample(sample_in_i);
      end
      if (out_valid_i && !out_stall_i) begin
        got.sample = sample_out_i;
        got.last   = cycle_last_i;
        if (replay_q.size() == 0) begin
          report_mismatch($sformatf("sample %0d last %0b with nothing expected",
                                    got.sample, got.last));
        end else begin
          want = replay_q.pop_front();
          if (got.sample !== want.sample) begin
            report_mismatch($sformatf("sample_out %0d, expected %0d",
                                      got.sample, want.sample));
          end
          if (got.last !== want.last) begin
            report_mismatch($sformatf("cycle_last %0b, expected %0b on sample %0d",
                                      got.last, want.last, want.sample));
          end
        end
      end
    end
    outstanding = replay_q.size();
  end

endmodule

>>> tb/testbench.sv
// top of the waveset length filter testbench: clock, reset, sample and register
// stimulus, replay stalls and the verdict
// depends on wlf_pkg, waveset_length_filter_top and wlf_replay_checker
module testbench;

  localparam int unsigned SampleBits   = wlf_pkg::SampleBitsDef;
  localparam int unsigned CycleStore   = wlf_pkg::CycleStoreDef;
  localparam int unsigned ModeBits     = wlf_pkg::ModeBits;
  localparam int unsigned LimitBits    = wlf_pkg::LimitBits;
  localparam int unsigned CfgIdxBits   = wlf_pkg::CfgIdxBits;
  localparam int unsigned CfgDataBits  = wlf_pkg::CfgDataBits;
  localparam int          MaxPos       = (1 << (SampleBits - 1)) - 1;
  localparam logic [ModeBits-1:0] ModeUnused = 2'd3;
  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned HoldCycles   = 160;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned PhaseSamples = 8;
  localparam int unsigned PhaseCount   = 9;

  typedef struct {
    logic [ModeBits-1:0]  mode;
    logic [LimitBits-1:0] long_lim;
    logic [LimitBits-1:0] short_lim;
    logic                 pol;
    int unsigned          long_len;
  } setting_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid;
  logic                         in_stall;
  logic signed [SampleBits-1:0] in_sample;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [SampleBits-1:0] out_sample;
  logic                         out_last;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CfgIdxBits-1:0]        cfg_index;
  logic [CfgDataBits-1:0]       cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent       = 0;
  int unsigned results_seen     = 0;
  int unsigned settings_applied = 0;
  logic        calm             = 1'b0;
  logic        cur_pol          = 1'b0;
  setting_t    plan [PhaseCount];

  waveset_length_filter_top #(
    .CycleStore(CycleStore),
    .SampleBits(SampleBits)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .sample_in_i (in_sample),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .sample_out_o(out_sample),
    .cycle_last_o(out_last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  wlf_replay_checker #(
    .CycleStore(CycleStore),
    .SampleBits(SampleBits)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .sample_in_i (in_sample),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .sample_out_i(out_sample),
    .cycle_last_i(out_last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
    end
  end

  // random magnitude of the given sign, full scale now and then
  function automatic logic signed [SampleBits-1:0] pick_sample(input int dir);
    int  magnitude;
    logic extreme;
    if (dir == 0) begin
      return '0;
    end
    extreme = ($urandom_range(0, 7) == 0);
    if (dir > 0) begin
      magnitude = extreme ? MaxPos : int'($urandom_range(1, MaxPos));
    end else begin
      magnitude = extreme ? -MaxPos - 1 : -int'($urandom_range(1, MaxPos + 1));
    end
    return SampleBits'(magnitude);
  endfunction

  task automatic push_sample(input logic signed [SampleBits-1:0] v);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    in_sample <= v;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    items_sent++;
  endtask

  // one well-formed pseudo-cycle, zeros sprinkled into both halves
  task automatic send_cycle(input int unsigned first_len, input int unsigned second_len);
    int lead;
    lead = cur_pol ? -1 : 1;
    push_sample(pick_sample(lead));
    for (int unsigned i = 1; i < first_len; i++) begin
      push_sample(pick_sample(($urandom_range(0, 3) == 0) ? 0 : lead));
    end
    push_sample(pick_sample(-lead));
    for (int unsigned i = 1; i < second_len; i++) begin
      push_sample(pick_sample(($urandom_range(0, 3) == 0) ? 0 : -lead));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx,
                           input logic [CfgDataBits-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input setting_t s);
    // unused upper data bits carry noise, the block must ignore them
    write_reg(wlf_pkg::RegFilterMode, {5'($urandom_range(0, 31)), s.mode});
    write_reg(wlf_pkg::RegLongLimit, s.long_lim);
    write_reg(wlf_pkg::RegShortLimit, s.short_lim);
    write_reg(wlf_pkg::RegStartPol, {6'($urandom_range(0, 63)), s.pol});
    write_reg(CfgIdxBits'($urandom_range(wlf_pkg::RegStartPol + 1, (1 << CfgIdxBits) - 1)),
              CfgDataBits'($urandom()));
    cfg_valid <= 1'b0;
    cur_pol = s.pol;
    settings_applied++;
  endtask

  task automatic run_phase(input int unsigned long_len);
    int unsigned start;
    int unsigned split;
    if (long_len != 0) begin
      split = $urandom_range(1, long_len - 1);
      send_cycle(split, long_len - split);
    end
    // ordinary cycles and stray samples follow; the first leading-sign sample closes any long cycle
    start = items_sent;
    while (items_sent - start < PhaseSamples) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 4)) push_sample(SampleBits'($urandom()));
      end else begin
        send_cycle($urandom_range(1, 6), $urandom_range(1, 6));
      end
    end
  endtask

  // replay side: random stall bursts plus one long hold while samples queue up
  initial begin : receiver
    logic        long_hold_done;
    int unsigned burst;
    long_hold_done = 1'b0;
    out_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && results_seen >= 20 && out_valid && in_valid) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 7);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
             IdleLimit, pending);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    // length-one cycle, zero runs, full scale values and alternating bit patterns
    int directed_pattern [23] = '{-5, 32767, 0, 0, -32768, 0, -1, 1, -1, 1, 0, 21845,
                                  -21846, -32768, 32767, 1, 0, -1, 0, 2, -2, 32766,
                                  -32767};
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;

    plan[0] = '{wlf_pkg::ModeHighPass, 7'd16, 7'd1, 1'b0, 0};
    plan[1] = '{wlf_pkg::ModeLowPass, 7'd64, 7'd6, 1'b1, 0};
    plan[2] = '{wlf_pkg::ModeBandPass, 7'd20, 7'd4, 1'b0, 0};
    plan[3] = '{ModeUnused, 7'd10, 7'd3, 1'b1, 0};
    plan[4] = '{wlf_pkg::ModeHighPass, 7'd0, 7'd0, 1'b0, 0};
    plan[5] = '{wlf_pkg::ModeBandPass, 7'd127, 7'd0, 1'b1, 66};
    plan[6] = '{wlf_pkg::ModeLowPass, 7'd64, 7'd64, 1'b0, 64};
    plan[7] = '{wlf_pkg::ModeBandPass, 7'd1, 7'd1, 1'b1, 0};
    plan[8] = '{wlf_pkg::ModeHighPass, wlf_pkg::LongLimitReset, wlf_pkg::ShortLimitReset,
                1'b0, 63};

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_pattern[i]) begin
      push_sample(SampleBits'(directed_pattern[i]));
    end
    drain();

    for (int p = 0; p < PhaseCount; p++) begin
      if (p == PhaseCount - 1) begin
        calm = 1'b1;
      end
      apply_setting(plan[p]);
      run_phase(plan[p].long_len);
      drain();
    end

    $display("covered %0d samples under %0d register settings plus the reset setting",
             items_sent, settings_applied);
    $display("%0d replayed samples checked, long cycles up to and past the store depth",
             results_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
